// File: src/b64e_pkg.sv
`timescale 1ns / 1ps

package b64e_pkg;

    // ascii codes used by the encoder
    localparam logic [6:0] PAD_CHAR   = 7'd61;  // '='
    localparam logic [6:0] PLUS_CHAR  = 7'd43;  // '+'
    localparam logic [6:0] SLASH_CHAR = 7'd47;  // '/'
    localparam logic [6:0] UPPER_A    = 7'd65;  // 'A'
    localparam logic [6:0] LOWER_A    = 7'd97;  // 'a'
    localparam logic [6:0] DIGIT_0    = 7'd48;  // '0'

    // one request's worth of output characters, passed from front to back
    typedef struct packed {
        logic [3:0][6:0] chars;     // characters in emit order, index 0 first
        logic [1:0]      last_idx;  // index of the final character (count - 1)
        logic            last;      // final character closes the message
    } t_entry;

    // map a sextet onto the standard alphabet
    function automatic logic [6:0] alpha(input logic [5:0] v);
        logic [6:0] v7;
        v7 = {1'b0, v};
        if (v < 6'd26) begin
            return UPPER_A + v7;
        end else if (v < 6'd52) begin
            return LOWER_A + v7 - 7'd26;
        end else if (v < 6'd62) begin
            return DIGIT_0 + v7 - 7'd52;
        end else if (v == 6'd62) begin
            return PLUS_CHAR;
        end else begin
            return SLASH_CHAR;
        end
    endfunction

endpackage

// File: src/base64_stream_encoder.sv
`timescale 1ns / 1ps

// base64 stream encoder, standard alphabet with '=' padding
// input stream: one message byte per request on s_axis, tlast marks the
//   final byte of a message
// output stream: one ascii character per request on m_axis, tlast marks
//   the final character of the encoded message
// a byte yields one or two characters as their sextets complete; the last
//   byte flushes any partial sextet and pads the group with up to two '='
// with the queue and back end idle, an accepted byte is written into the
//   queue, then loaded into the back end's held entry, from which the first
//   character of the byte is presented
// throughput: one character per cycle at the output while the receiver is
//   ready and entries are waiting, set by the back end handing out one
//   character of its held entry per cycle; bytes are taken back to back as
//   long as the two-entry queue between front and back has room, and a byte
//   yields one or two characters (up to four for a closing byte)
// when the receiver stalls, characters hold and the queue fills; s_axis
//   tready drops only once both queue entries are occupied
// reset clears the group position, the queue and the output; the encoder
//   then starts at the beginning of a group

module base64_stream_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast    // out_last
);

    b64e_pkg::t_entry w_push_entry;
    b64e_pkg::t_entry w_head_entry;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    logic [6:0]       w_char;

    // front: group tracking and character build
    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_eom   (s_axis_tlast),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // queue between front and back
    b64e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_entry (w_head_entry)
    );

    // back: character serializer
    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_entry (w_head_entry),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_char  (w_char),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

endmodule

// File: src/b64e_front.sv
`timescale 1ns / 1ps

module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_eom,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output b64e_pkg::t_entry o_entry
);

    typedef enum logic [1:0] {
        POS0,
        POS1,
        POS2
    } t_pos;

    t_pos       r_pos, n_pos;
    logic [3:0] r_left, n_left;

    // accept whenever the queue has room
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // classify the byte by group position and build its characters
    always_comb begin
        o_entry.chars    = '0;
        o_entry.last_idx = 2'd0;
        o_entry.last     = i_eom;
        n_pos            = r_pos;
        n_left           = r_left;
        unique case (r_pos)
            POS1: begin
                o_entry.chars[0] = b64e_pkg::alpha({r_left[1:0], i_byte[7:4]});
                if (i_eom) begin
                    o_entry.chars[1] = b64e_pkg::alpha({i_byte[3:0], 2'b00});
                    o_entry.chars[2] = b64e_pkg::PAD_CHAR;
                    o_entry.last_idx = 2'd2;
                end else begin
                    n_pos  = POS2;
                    n_left = i_byte[3:0];
                end
            end
            POS2: begin
                o_entry.chars[0] = b64e_pkg::alpha({r_left, i_byte[7:6]});
                o_entry.chars[1] = b64e_pkg::alpha(i_byte[5:0]);
                o_entry.last_idx = 2'd1;
                n_pos            = POS0;
                n_left           = 4'd0;
            end
            default: begin
                o_entry.chars[0] = b64e_pkg::alpha(i_byte[7:2]);
                if (i_eom) begin
                    o_entry.chars[1] = b64e_pkg::alpha({i_byte[1:0], 4'b0000});
                    o_entry.chars[2] = b64e_pkg::PAD_CHAR;
                    o_entry.chars[3] = b64e_pkg::PAD_CHAR;
                    o_entry.last_idx = 2'd3;
                end else begin
                    n_pos  = POS1;
                    n_left = {2'b00, i_byte[1:0]};
                end
            end
        endcase
        // end of message returns to the start of a group
        if (i_eom) begin
            n_pos  = POS0;
            n_left = 4'd0;
        end
    end

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS0;
            r_left <= 4'd0;
        end else if (o_push) begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

endmodule

// File: src/b64e_fifo.sv
`timescale 1ns / 1ps

module b64e_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output b64e_pkg::t_entry o_entry
);

    localparam int DEPTH = 2;

    b64e_pkg::t_entry r_mem [DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: src/b64e_back.sv
`timescale 1ns / 1ps

module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  b64e_pkg::t_entry i_entry,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [6:0]       o_char,
    output logic             o_last
);

    b64e_pkg::t_entry r_entry;
    logic [1:0]       r_idx;
    logic             r_busy;
    logic             w_final;

    // current entry drains one character per taken request
    assign w_final = (r_idx == r_entry.last_idx);
    assign o_valid = r_busy;
    assign o_char  = r_entry.chars[r_idx];
    assign o_last  = r_entry.last && w_final;
    assign o_pop   = !i_empty && (!r_busy || (i_ready && w_final));

    // held entry and character index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (r_busy && i_ready) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

endmodule

// File: bench/b64_char_checker.sv
`timescale 1ns / 1ps

// watches both streams of the encoder, predicts the characters of every
// accepted request and compares them in order with the output stream
module b64_char_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] data_byte
    input  logic       i_s_tlast,    // end_of_message
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [6:0] out_char, [7] zero
    input  logic       i_m_tlast,    // out_last
    output int         o_fail_count,
    output int         o_pending,
    output int         o_chars_checked
);

    typedef enum logic [1:0] {
        GRP_FIRST  = 2'd0,
        GRP_SECOND = 2'd1,
        GRP_THIRD  = 2'd2
    } t_grp_pos;

    typedef struct packed {
        logic [6:0] code;
        logic       eom;
    } t_b64_char;

    string      b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    t_grp_pos   grp_pos;
    logic [3:0] carry_bits;
    t_b64_char  expected_chars[$];
    int         mismatches;
    int         chars_seen;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        byte c;
        c = b64_set[v];
        return c[6:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // encoder state after one byte, expected characters queued in order
    task automatic predict_chars(input logic [7:0] b, input logic eom);
        logic [6:0] codes[4];
        int         n;
        n = 0;
        case (grp_pos)
            GRP_SECOND: begin
                codes[0] = sextet_char({carry_bits[1:0], b[7:4]});
                n = 1;
                if (eom) begin
                    codes[1] = sextet_char({b[3:0], 2'b00});
                    codes[2] = b64e_pkg::PAD_CHAR;
                    n = 3;
                end else begin
                    grp_pos    = GRP_THIRD;
                    carry_bits = b[3:0];
                end
            end
            GRP_THIRD: begin
                codes[0]   = sextet_char({carry_bits, b[7:6]});
                codes[1]   = sextet_char(b[5:0]);
                n          = 2;
                grp_pos    = GRP_FIRST;
                carry_bits = 4'd0;
            end
            default: begin
                codes[0] = sextet_char(b[7:2]);
                n = 1;
                if (eom) begin
                    codes[1] = sextet_char({b[1:0], 4'b0000});
                    codes[2] = b64e_pkg::PAD_CHAR;
                    codes[3] = b64e_pkg::PAD_CHAR;
                    n = 4;
                end else begin
                    grp_pos    = GRP_SECOND;
                    carry_bits = {2'b00, b[1:0]};
                end
            end
        endcase
        // message end closes the group
        if (eom) begin
            grp_pos    = GRP_FIRST;
            carry_bits = 4'd0;
        end
        for (int i = 0; i < n; i++)
            expected_chars.push_back('{code: codes[i], eom: eom && (i == n - 1)});
    endtask

    // predict on input requests, compare on output requests
    always @(posedge i_clk) begin
        t_b64_char exp_c;
        if (!i_rst_n) begin
            grp_pos    = GRP_FIRST;
            carry_bits = 4'd0;
            expected_chars.delete();
            mismatches = 0;
            chars_seen = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_chars(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h", i_m_tdata));
                end else begin
                    exp_c = expected_chars.pop_front();
                    if (i_m_tdata !== {1'b0, exp_c.code})
                        report_mismatch($sformatf("char %0d: got 0x%02h, want 0x%02h",
                                                  chars_seen, i_m_tdata, exp_c.code));
                    if (i_m_tlast !== exp_c.eom)
                        report_mismatch($sformatf("char %0d: last got %b, want %b",
                                                  chars_seen, i_m_tlast, exp_c.eom));
                end
            end
        end
        o_fail_count    <= mismatches;
        o_pending       <= expected_chars.size();
        o_chars_checked <= chars_seen;
    end

endmodule

// File: bench/tb_base64_stream_encoder.sv
`timescale 1ns / 1ps

module tb_base64_stream_encoder;

    typedef enum logic [1:0] {
        RX_ALWAYS = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_BURSTY = 2'd3
    } t_rx_mode;

    localparam int RANDOM_BYTES = 480;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic       s_axis_tlast;   // end_of_message
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [6:0] out_char, [7] zero
    logic       m_axis_tlast;   // out_last

    int         fail_count;
    int         pending;
    int         chars_checked;

    logic [7:0] msg_bytes[$];
    int         burst_left;
    int         bytes_sent;
    int         msgs_sent;
    int         longest_msg;
    int         ends_at[3];

    base64_stream_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    b64_char_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tlast       (s_axis_tlast),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tlast       (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_chars_checked (chars_checked)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // run limit
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver back-pressure, switching between stall patterns
    initial begin
        t_rx_mode rx_mode;
        int       stall_run;
        stall_run     = 0;
        m_axis_tready = 1'b0;
        forever begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            repeat ($urandom_range(20, 120)) begin
                @(negedge i_clk);
                case (rx_mode)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if (stall_run > 0) begin
                            stall_run--;
                            m_axis_tready <= 1'b0;
                        end else if ($urandom_range(0, 7) == 0) begin
                            stall_run     = $urandom_range(4, 12);
                            m_axis_tready <= 1'b0;
                        end else begin
                            m_axis_tready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // one byte request in bursts with random gaps; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 8'($urandom);
                s_axis_tlast  <= 1'($urandom_range(0, 1));
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eom;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // whole message from msg_bytes, last byte flagged
    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msgs_sent++;
        ends_at[msg_bytes.size() % 3]++;
        if (msg_bytes.size() > longest_msg)
            longest_msg = msg_bytes.size();
    endtask

    // hold off until every expected character has come out
    task automatic drain_output(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    initial begin
        int  len;
        bit  drained_mid;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        burst_left    = 0;
        bytes_sent    = 0;
        msgs_sent     = 0;
        longest_msg   = 0;
        ends_at       = '{0, 0, 0};
        drained_mid   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes ending at every group position, '+' and '/' runs
        msg_bytes = '{8'h00};                      send_message();
        msg_bytes = '{8'hFF};                      send_message();
        msg_bytes = '{8'h00, 8'hFF};               send_message();
        msg_bytes = '{8'hFF, 8'h00};               send_message();
        msg_bytes = '{8'h00, 8'h00, 8'h00};        send_message();
        msg_bytes = '{8'hFF, 8'hFF, 8'hFF};        send_message();
        msg_bytes = '{8'hFB, 8'hEF, 8'hBE};        send_message();
        msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_message();
        msg_bytes = '{8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h81}; send_message();
        drain_output(4);

        // random messages, mostly short, a few long
        while (bytes_sent < RANDOM_BYTES + 24) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(1, 7);
            msg_bytes.delete();
            repeat (len) begin
                case ($urandom_range(0, 9))
                    0:       msg_bytes.push_back(8'h00);
                    1:       msg_bytes.push_back(8'hFF);
                    default: msg_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            send_message();
            if (!drained_mid && bytes_sent > RANDOM_BYTES / 2) begin
                drained_mid = 1'b1;
                drain_output(3);
            end
        end

        drain_output(10);
        $display("covered %0d messages, %0d bytes, %0d characters checked, longest message %0d",
                 msgs_sent, bytes_sent, chars_checked, longest_msg);
        $display("message ends after 1/2/3 bytes of a group: %0d/%0d/%0d,",
                 ends_at[1], ends_at[2], ends_at[0]);
        $display("with sender gaps and receiver stalls");
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
